/* src/spl_pkg.sv */
// Shared types and codes for the sorted posting list core.
`default_nettype none

package spl_pkg;

  // Default number of cells in the chain
  localparam int unsigned DEFAULT_LIST_DEPTH = 256;

  localparam int unsigned ID_W     = 64;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned ECOUNT_W = 9;

  // Request opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_ERASE  = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic cmp;   // latch compare flags against the key
    logic ins;   // open a slot at the insertion point
    logic del;   // close the slot of the matched entry
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* src/spl_cell.sv */
// One cell of the sorted list: holds one entry, compares it with the key, shifts.
`default_nettype none

module spl_cell
  import spl_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 9
) (
  input  wire                   clk,
  input  wire cell_ctrl_t       ctrl,
  input  wire logic signed [ID_W-1:0] key,
  input  wire logic [CW-1:0]    count,
  input  wire logic signed [ID_W-1:0] left_entry,
  input  wire logic             left_ge,
  input  wire logic signed [ID_W-1:0] right_entry,
  output logic signed [ID_W-1:0] entry,
  output logic                  ge,
  output logic                  eq
);

  logic [CW-1:0] idx_c;
  logic          held;

  assign idx_c = CW'(IDX);
  // Cell holds a live entry when its position is below the fill count
  assign held  = count > idx_c;

  // Compare flags: ge marks cells at or past the key's sorted position
  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      ge <= !(held && (entry < key));
      eq <= held && (entry == key);
    end
  end

  // Shift right to open a slot, or left to close one
  always_ff @(posedge clk) begin
    if (ctrl.ins && ge) begin
      entry <= left_ge ? left_entry : key;
    end else if (ctrl.del && ge) begin
      entry <= right_entry;
    end
  end

endmodule

`default_nettype wire

/* src/sorted_posting_list_core.sv */
// Sorted set of signed 64-bit row identifiers built as a chain of compare/shift cells.
// Each request steps through the compare, match-reduce and apply states, which every
// cell follows for each request; the result is registered in the apply state. A new
// request is taken while idle, or in the apply state once the output register is free.
// Reset empties the list at once (fill count cleared); cell storage is not cleared.
// A result may wait in the output register while the next request is taken.
`default_nettype none

module sorted_posting_list_core
  import spl_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  op,
  input  wire logic signed [ID_W-1:0] row_id,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [STATUS_W-1:0]        status,
  output logic [ECOUNT_W-1:0]        entry_count
);

  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMP   = 4'b0010,
    S_RED   = 4'b0100,
    S_APPLY = 4'b1000
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic signed [ID_W-1:0] key;
  logic                   op_q;
  logic                   found;
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic                   out_free;
  logic                   in_take;
  logic                   apply_go;
  logic                   full;
  cell_ctrl_t             ctrl;
  status_t                status_next;
  logic [CW+ECOUNT_W-1:0] count_wide;

  logic signed [ID_W-1:0] entry_a [LIST_DEPTH];
  logic                   ge_a    [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]  eq_vec;

  // Handshake
  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == S_IDLE) || ((state == S_APPLY) && out_free));
  assign in_take  = in_valid && !in_stall;
  assign apply_go = (state == S_APPLY) && out_free;
  assign full     = count == CW'(LIST_DEPTH);

  // Cell control
  always_comb begin
    ctrl.cmp = state == S_CMP;
    ctrl.ins = apply_go && (op_q == OP_INSERT) && !found && !full;
    ctrl.del = apply_go && (op_q == OP_ERASE) && found;
  end

  // Result status and new fill count
  always_comb begin
    count_next = count;
    if (op_q == OP_INSERT) begin
      if (found) begin
        status_next = ST_PRESENT;
      end else if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_INSERTED;
        count_next  = count + CW'(1);
      end
    end else begin
      if (found) begin
        status_next = ST_REMOVED;
        count_next  = count - CW'(1);
      end else begin
        status_next = ST_NOTFOUND;
      end
    end
  end

  assign count_wide = {{ECOUNT_W{1'b0}}, count_next};

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_take) state_next = S_CMP;
      S_CMP:   state_next = S_RED;
      S_RED:   state_next = S_APPLY;
      S_APPLY: if (out_free) state_next = in_take ? S_CMP : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (apply_go) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture, match reduce and result payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      key  <= row_id;
      op_q <= op;
    end
    if (state == S_RED) begin
      found <= |eq_vec;
    end
    if (apply_go) begin
      status      <= status_next;
      entry_count <= count_wide[ECOUNT_W-1:0];
    end
  end

  // Chain of cells
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic signed [ID_W-1:0] left_entry;
    logic                   left_ge;
    logic signed [ID_W-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_ge    = 1'b0;
    end else begin : g_mid
      assign left_entry = entry_a[i-1];
      assign left_ge    = ge_a[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = entry_a[i+1];
    end

    spl_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .key         (key),
      .count       (count),
      .left_entry  (left_entry),
      .left_ge     (left_ge),
      .right_entry (right_entry),
      .entry       (entry_a[i]),
      .ge          (ge_a[i]),
      .eq          (eq_vec[i])
    );
  end

endmodule

`default_nettype wire
